// ===== src/vtp_pkg.sv =====
`default_nettype none

package vtp_pkg;

  // pipeline depth: input stage, four work stages, output register
  localparam int NSTG = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic [NSTG-1:0] stage_en_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WIDTH  = 3'd0,
    REG_ACTIVE_HEIGHT = 3'd1,
    REG_INTERLACED    = 3'd2,
    REG_PROG_BUFFER   = 3'd3,
    REG_NOISE         = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic interlaced;
    logic prog_buf;
    logic noise;
  } cfg_flags_t;

  // red in the top byte, blue in the low byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 12'd480;

  localparam logic [31:0] HASH_SEED      = 32'h9e3779b9;
  localparam logic [31:0] HASH_MUL_FRAME = 32'h85ebca6b;
  localparam logic [31:0] HASH_MUL_COL   = 32'hc2b2ae35;
  localparam logic [31:0] HASH_MUL_ROW   = 32'h27d4eb2f;
  localparam logic [31:0] HASH_MIX_A     = 32'h7feb352d;
  localparam logic [31:0] HASH_MIX_B     = 32'h846ca68b;

  localparam pixel_t BAR_COLORS [8] = '{
    24'hFFFFFF, 24'hFFFF00, 24'h00FFFF, 24'h00FF00,
    24'hFF00FF, 24'hFF0000, 24'h0000FF, 24'h000000
  };

endpackage

`default_nettype wire

// ===== src/vtp_coord.sv =====
`default_nettype none

module vtp_coord
  import vtp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire stage_en_t             en_i,
  input  wire cfg_flags_t            flags_i,
  input  wire logic [COORD_BITS-1:0] width_i,
  input  wire logic [COORD_BITS-1:0] col_i,
  input  wire logic [COORD_BITS-1:0] row_i,
  input  wire logic [31:0]           frame_i,
  input  wire logic                  odd_i,
  output logic      [COORD_BITS-1:0] col_o,
  output logic      [COORD_BITS:0]   row_o,
  output logic      [31:0]           frame_o,
  output logic                       odd_o,
  output logic                       sat_o,
  output logic                       q2_o,
  output logic      [COORD_BITS+2:0] rem_o
);

  logic [COORD_BITS-1:0] col_q;
  logic [COORD_BITS:0]   row_d, row_q;
  logic [31:0]           frame_q;
  logic                  odd_q;
  logic                  sat_d, sat_q;
  logic                  q2_d, q2_q;
  logic [COORD_BITS+2:0] rem_d, rem_q;
  logic [COORD_BITS+2:0] col_x8;
  logic [COORD_BITS+2:0] width_x4;

  always_comb begin
    // field buffer: even field sits on odd frame lines
    if (flags_i.interlaced && !flags_i.prog_buf) begin
      row_d = {row_i, ~odd_i};
    end else begin
      row_d = {1'b0, row_i};
    end
    // first quotient bit of col*8/width
    col_x8   = {col_i, 3'b000};
    width_x4 = {1'b0, width_i, 2'b00};
    q2_d     = (col_x8 >= width_x4);
    rem_d    = q2_d ? (col_x8 - width_x4) : col_x8;
    // past the last bar, also covers zero width
    sat_d    = (col_i >= width_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      col_q   <= col_i;
      row_q   <= row_d;
      frame_q <= frame_i;
      odd_q   <= odd_i;
      sat_q   <= sat_d;
      q2_q    <= q2_d;
      rem_q   <= rem_d;
    end
  end

  assign col_o   = col_q;
  assign row_o   = row_q;
  assign frame_o = frame_q;
  assign odd_o   = odd_q;
  assign sat_o   = sat_q;
  assign q2_o    = q2_q;
  assign rem_o   = rem_q;

endmodule

`default_nettype wire

// ===== src/vtp_hash.sv =====
`default_nettype none

module vtp_hash
  import vtp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire stage_en_t             en_i,
  input  wire logic [COORD_BITS-1:0] col_i,
  input  wire logic [COORD_BITS:0]   row_i,
  input  wire logic [31:0]           frame_i,
  output logic      [31:0]           hash_o
);

  logic [31:0] pf_d, pf_q, pc_d, pc_q, pr_d, pr_q;
  logic [31:0] mix0, h3_d, h3_q;
  logic [31:0] h4_d, h4_q;
  logic [31:0] mix1, h5_d, h5_q;

  always_comb begin
    pf_d = frame_i * HASH_MUL_FRAME;
    pc_d = {{(32-COORD_BITS){1'b0}}, col_i} * HASH_MUL_COL;
    pr_d = {{(31-COORD_BITS){1'b0}}, row_i} * HASH_MUL_ROW;
    mix0 = HASH_SEED ^ pf_q ^ pc_q ^ pr_q;
    h3_d = mix0 ^ (mix0 >> 16);
    h4_d = h3_q * HASH_MIX_A;
    mix1 = h4_q ^ (h4_q >> 15);
    h5_d = mix1 * HASH_MIX_B;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pf_q <= pf_d;
      pc_q <= pc_d;
      pr_q <= pr_d;
    end
    if (en_i[2]) begin
      h3_q <= h3_d;
    end
    if (en_i[3]) begin
      h4_q <= h4_d;
    end
    if (en_i[4]) begin
      h5_q <= h5_d;
    end
  end

  assign hash_o = h5_q;

endmodule

`default_nettype wire

// ===== src/vtp_bars.sv =====
`default_nettype none

module vtp_bars
  import vtp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire stage_en_t             en_i,
  input  wire logic [COORD_BITS-1:0] width_i,
  input  wire logic [COORD_BITS-1:0] height_i,
  input  wire logic [COORD_BITS-1:0] col_i,
  input  wire logic [COORD_BITS:0]   row_i,
  input  wire logic                  frame_lsb_i,
  input  wire logic                  odd_i,
  input  wire logic                  sat_i,
  input  wire logic                  q2_i,
  input  wire logic [COORD_BITS+2:0] rem_i,
  output pixel_t                     pix_o
);

  logic [COORD_BITS-1:0] min_side, side_raw, side;
  logic [COORD_BITS+2:0] width_x2, rem2_d, rem2_q;
  logic                  q1_d, q1_q, q2_q, sat_q;
  logic                  tl_d, tl_q, br_d, br_q;
  logic                  flash_q, odd_q;
  logic                  q0;
  logic [2:0]            idx;
  pixel_t                pix3_d, pix3_q, pix4_q, pix5_q;

  // stage 2: second quotient bit and marker hits
  always_comb begin
    width_x2 = {2'b00, width_i, 1'b0};
    q1_d     = (rem_i >= width_x2);
    rem2_d   = q1_d ? (rem_i - width_x2) : rem_i;
    min_side = (width_i < height_i) ? width_i : height_i;
    side_raw = min_side >> 3;
    side     = (side_raw == '0) ? COORD_BITS'(1) : side_raw;
    tl_d     = (col_i < side) && (row_i < {1'b0, side});
    br_d     = (width_i >= side) && (height_i >= side) &&
               (col_i >= width_i - side) && (row_i >= {1'b0, height_i - side});
  end

  // stage 3: last quotient bit and color pick
  always_comb begin
    q0  = (rem2_q >= {3'b000, width_i});
    idx = sat_q ? 3'd7 : {q2_q, q1_q, q0};
    pix3_d = BAR_COLORS[idx];
    if (tl_q) begin
      pix3_d.blue  = flash_q ? 8'h00 : 8'hFF;
      pix3_d.green = flash_q ? 8'h00 : 8'hFF;
      pix3_d.red   = flash_q ? 8'h00 : 8'hFF;
    end else if (br_q) begin
      pix3_d.blue  = odd_q ? 8'h00 : 8'hFF;
      pix3_d.green = odd_q ? 8'hFF : 8'h00;
      pix3_d.red   = 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sat_q   <= sat_i;
      q2_q    <= q2_i;
      q1_q    <= q1_d;
      rem2_q  <= rem2_d;
      tl_q    <= tl_d;
      br_q    <= br_d;
      flash_q <= frame_lsb_i;
      odd_q   <= odd_i;
    end
    if (en_i[2]) begin
      pix3_q <= pix3_d;
    end
    // delay to line up with the hash
    if (en_i[3]) begin
      pix4_q <= pix3_q;
    end
    if (en_i[4]) begin
      pix5_q <= pix4_q;
    end
  end

  assign pix_o = pix5_q;

endmodule

`default_nettype wire

// ===== src/video_test_pattern_pixel_top.sv =====
// each input beat passes the input stage, the work stages and the output register
// one pixel per cycle unless stalled; the two chained 32-bit multiplies of the
// noise hash and the three restoring steps of the bar index each own a stage
// reset: pipeline valid bits clear, registers return to 640x480 progressive bars
// stalls ripple back stage by stage so empty stages keep filling
`default_nettype none

module video_test_pattern_pixel_top
  import vtp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // pixel_column, output_row, frame_number[32], field_parity, zero pad
  input  wire logic [((2*COORD_BITS+33+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // blue_byte, green_byte, red_byte
  output logic      [23:0]           m_axis_tdata_o
);

  localparam int RowLo   = COORD_BITS;
  localparam int FrameLo = 2 * COORD_BITS;
  localparam int OddBit  = 2 * COORD_BITS + 32;

  logic [CFG_DATA_W-1:0] width_q, height_q;
  cfg_flags_t            flags_q;
  logic [COORD_BITS-1:0] width_c, height_c;

  stage_en_t en;
  logic [NSTG-1:0] valid_d, valid_q;

  logic [COORD_BITS-1:0] col1;
  logic [COORD_BITS:0]   row1;
  logic [31:0]           frame1;
  logic                  odd1, sat1, q2_1;
  logic [COORD_BITS+2:0] rem1;
  logic [31:0]           hash5, hash_fin;
  pixel_t                bars5, pix_d, pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      flags_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_WIDTH:  width_q          <= cfg_data_i;
        REG_ACTIVE_HEIGHT: height_q         <= cfg_data_i;
        REG_INTERLACED:    flags_q.interlaced <= cfg_data_i[0];
        REG_PROG_BUFFER:   flags_q.prog_buf <= cfg_data_i[0];
        REG_NOISE:         flags_q.noise    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign width_c  = COORD_BITS'(width_q);
  assign height_c = COORD_BITS'(height_q);

  // a stage loads when it is empty or the one after it loads
  always_comb begin
    en[NSTG-1] = !valid_q[NSTG-1] || m_axis_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = s_axis_tvalid_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  vtp_coord #(
    .COORD_BITS(COORD_BITS)
  ) u_coord (
    .clk_i   (clk_i),
    .en_i    (en),
    .flags_i (flags_q),
    .width_i (width_c),
    .col_i   (s_axis_tdata_i[COORD_BITS-1:0]),
    .row_i   (s_axis_tdata_i[RowLo+COORD_BITS-1:RowLo]),
    .frame_i (s_axis_tdata_i[FrameLo+31:FrameLo]),
    .odd_i   (s_axis_tdata_i[OddBit]),
    .col_o   (col1),
    .row_o   (row1),
    .frame_o (frame1),
    .odd_o   (odd1),
    .sat_o   (sat1),
    .q2_o    (q2_1),
    .rem_o   (rem1)
  );

  vtp_hash #(
    .COORD_BITS(COORD_BITS)
  ) u_hash (
    .clk_i   (clk_i),
    .en_i    (en),
    .col_i   (col1),
    .row_i   (row1),
    .frame_i (frame1),
    .hash_o  (hash5)
  );

  vtp_bars #(
    .COORD_BITS(COORD_BITS)
  ) u_bars (
    .clk_i       (clk_i),
    .en_i        (en),
    .width_i     (width_c),
    .height_i    (height_c),
    .col_i       (col1),
    .row_i       (row1),
    .frame_lsb_i (frame1[0]),
    .odd_i       (odd1),
    .sat_i       (sat1),
    .q2_i        (q2_1),
    .rem_i       (rem1),
    .pix_o       (bars5)
  );

  always_comb begin
    hash_fin = hash5 ^ (hash5 >> 16);
    pix_d    = flags_q.noise ? pixel_t'(hash_fin[23:0]) : bars5;
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      pix_q <= pix_d;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = valid_q[NSTG-1];
  assign m_axis_tdata_o  = pix_q;

endmodule

`default_nettype wire

// ===== src/vtp_checker.sv =====
`default_nettype none

module vtp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output beat valid during reset");

  // a ready sink never stalls the source
  a_ready_flows: assert property (@(posedge clk_i)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output is ready");

  // an empty output stage always leaves room upstream
  a_empty_takes: assert property (@(posedge clk_i)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with no output beat pending");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output beat changed");

  // nothing leaves in the cycle right after reset release
  a_no_early_beat: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output beat right after reset");

endmodule

bind video_test_pattern_pixel_top vtp_checker u_vtp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
